>>> rtl/core/pdp_pkg.sv
// ----------------------------------------------------------------------------
// pdp_pkg: shared types and constants of the page-distance prefetcher
// Address and distance widths, table geometry, queue and table entry layouts.
// ----------------------------------------------------------------------------
package pdp_pkg;

  localparam int ADDR_W      = 64;
  localparam int PAGE_SHIFT  = 12;
  localparam int DIST_W      = ADDR_W - PAGE_SHIFT;
  // Power of two: the set index is the low bits of the distance.
  localparam int TABLE_SETS  = 64;
  localparam int SET_W       = $clog2(TABLE_SETS);
  // Power of two: queue pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [SET_W-1:0]  set_t;

  // One classified access, handed from front to back.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    dist_t             distance;
  } work_t;

  // One table entry: single way, single successor slot.
  typedef struct packed {
    dist_t tag;
    logic  slot_valid;
    dist_t succ;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_LOOK = 2'b01,
    ST_EVAL = 2'b10
  } back_state_t;

  function automatic set_t set_of(dist_t d);
    return d[SET_W-1:0];
  endfunction

endpackage

>>> rtl/core/pdp_access_if.sv
// ----------------------------------------------------------------------------
// pdp_access_if: demand access channel
// Valid/ready channel that carries one access address per item.
// ----------------------------------------------------------------------------
interface pdp_access_if;
  logic                        valid;
  logic                        ready;
  logic [pdp_pkg::ADDR_W-1:0]  access_address;

  modport source (output valid, output access_address, input ready);
  modport sink   (input valid, input access_address, output ready);
endinterface

>>> rtl/core/pdp_prefetch_if.sv
// ----------------------------------------------------------------------------
// pdp_prefetch_if: prefetch request channel
// Valid/ready channel that carries one prefetch address per item.
// ----------------------------------------------------------------------------
interface pdp_prefetch_if;
  logic                        valid;
  logic                        ready;
  logic [pdp_pkg::ADDR_W-1:0]  prefetch_address;
  logic                        last_prefetch;

  modport source (output valid, output prefetch_address, output last_prefetch, input ready);
  modport sink   (input valid, input prefetch_address, input last_prefetch, output ready);
endinterface

>>> rtl/core/page_distance_prefetcher_core.sv
// ----------------------------------------------------------------------------
// page_distance_prefetcher_core: page-distance prefetcher top level
// Learns which page distance follows which and prefetches the successor.
// ----------------------------------------------------------------------------
//
//   channel     dir  handshake        payload
//   ----------  ---  ---------------  -----------------------------------
//   access      in   valid / ready    access_address [63:0]
//   prefetch    out  valid / ready    prefetch_address [63:0], last_prefetch
//   cfg         in   cfg_we           cfg_wdata -> warmup_mode
//
// In the back end, the look state reads the 64-set table at the current
// distance's set and may link the prior entry; the evaluate state compares
// the tag, issues the prefetch and writes back the fill or successor link
// over the table's single write port. The front end takes a new access
// every cycle while its two-item queue has room, so intake runs ahead.
// Reset clears the entry valid bits directly; no clearing pass.
// A held prefetch stalls only the back end, while the queue has room.
//
module page_distance_prefetcher_core (
  input  logic            clk,
  input  logic            rst,
  pdp_access_if.sink      access,
  pdp_prefetch_if.source  prefetch,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  // Classified accesses waiting for the table.
  pdp_pkg::work_t head;
  logic           head_valid;
  logic           head_ready;

  // Compute distances and buffer them.
  pdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .access     (access),
    .head       (head),
    .head_valid (head_valid),
    .head_ready (head_ready)
  );

  // Look up, update the table and issue prefetches.
  pdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .head_valid (head_valid),
    .head_ready (head_ready),
    .prefetch   (prefetch)
  );

endmodule

>>> rtl/core/pdp_ram.sv
// ----------------------------------------------------------------------------
// pdp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pdp_front.sv
// ----------------------------------------------------------------------------
// pdp_front: access intake and distance classification
// Compute the page distance of each access and queue it for the back end.
// ----------------------------------------------------------------------------
module pdp_front (
  input  logic            clk,
  input  logic            rst,
  pdp_access_if.sink      access,
  output pdp_pkg::work_t  head,
  output logic            head_valid,
  input  logic            head_ready
);

  logic [pdp_pkg::ADDR_W-1:0] prior_address;
  pdp_pkg::work_t             queue [pdp_pkg::QUEUE_DEPTH];
  logic [pdp_pkg::QPTR_W-1:0] wr_ptr;
  logic [pdp_pkg::QPTR_W-1:0] rd_ptr;
  logic [pdp_pkg::QPTR_W:0]   count;

  logic [pdp_pkg::ADDR_W-1:0] diff;
  pdp_pkg::dist_t             distance;
  logic                       push;
  logic                       pop;

  // Arithmetic shift of the wrapped difference is its upper bits.
  assign diff     = access.access_address - prior_address;
  assign distance = diff[pdp_pkg::ADDR_W-1:pdp_pkg::PAGE_SHIFT];

  assign access.ready = (count != (pdp_pkg::QPTR_W+1)'(pdp_pkg::QUEUE_DEPTH));
  assign push         = access.valid && access.ready;
  assign head_valid   = (count != '0);
  assign pop          = head_valid && head_ready;
  assign head         = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_address <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (push) begin
        prior_address <= access.access_address;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{addr: access.access_address, distance: distance};
    end
  end

endmodule

>>> rtl/core/pdp_back.sv
// ----------------------------------------------------------------------------
// pdp_back: table lookup, update and prefetch issue
// Look up the current distance, issue its successor, fill or link entries.
// ----------------------------------------------------------------------------
module pdp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  pdp_pkg::work_t  head,
  input  logic            head_valid,
  output logic            head_ready,
  pdp_prefetch_if.source  prefetch
);

  pdp_pkg::back_state_t           state;
  logic                           warmup_mode;
  pdp_pkg::dist_t                 prior_distance;
  logic [pdp_pkg::TABLE_SETS-1:0] vld;
  pdp_pkg::work_t                 cur;
  logic                           out_valid;
  logic [pdp_pkg::ADDR_W-1:0]     out_addr;

  logic                           ram_we;
  pdp_pkg::set_t                  ram_waddr;
  pdp_pkg::entry_t                ram_wdata;
  logic                           ram_re;
  logic [pdp_pkg::ENTRY_W-1:0]    ram_rdata;
  pdp_pkg::entry_t                rd_entry;

  pdp_pkg::set_t                  head_set;
  pdp_pkg::set_t                  prior_set;
  pdp_pkg::set_t                  cur_set;
  logic                           hit;
  logic                           emit;
  logic                           look_go;
  logic                           eval_go;
  logic [pdp_pkg::ADDR_W-1:0]     pf_addr;

  assign head_set  = pdp_pkg::set_of(head.distance);
  assign prior_set = pdp_pkg::set_of(prior_distance);
  assign cur_set   = pdp_pkg::set_of(cur.distance);
  assign rd_entry  = pdp_pkg::entry_t'(ram_rdata);

  assign hit     = vld[cur_set] && (rd_entry.tag == cur.distance);
  assign emit    = hit && !warmup_mode && rd_entry.slot_valid;
  assign look_go = (state == pdp_pkg::ST_LOOK) && head_valid;
  assign eval_go = (state == pdp_pkg::ST_EVAL) && (!emit || !out_valid || prefetch.ready);
  assign pf_addr = cur.addr + {rd_entry.succ, {pdp_pkg::PAGE_SHIFT{1'b0}}};

  assign head_ready = (state == pdp_pkg::ST_LOOK);
  assign ram_re     = look_go;

  // Link in the look cycle when the prior entry sits in another set; in the same set,
  // fill and link merge into one write in the evaluate cycle only for an equal distance.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_set;
    ram_wdata = '{tag: cur.distance, slot_valid: 1'b0, succ: '0};
    case (state)
      pdp_pkg::ST_LOOK: begin
        ram_waddr = prior_set;
        ram_wdata = '{tag: prior_distance, slot_valid: 1'b1, succ: head.distance};
        ram_we    = look_go && (prior_set != head_set) && vld[prior_set];
      end
      pdp_pkg::ST_EVAL: begin
        if (prior_distance == cur.distance) begin
          ram_wdata = '{tag: cur.distance, slot_valid: 1'b1, succ: cur.distance};
          ram_we    = eval_go;
        end else begin
          ram_we    = eval_go && !hit;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pdp_ram #(
    .WIDTH (pdp_pkg::ENTRY_W),
    .DEPTH (pdp_pkg::TABLE_SETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_set),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pdp_pkg::ST_LOOK;
      warmup_mode    <= 1'b0;
      prior_distance <= '0;
      vld            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        warmup_mode <= cfg_wdata;
      end
      case (state)
        pdp_pkg::ST_LOOK: begin
          if (look_go) begin
            state <= pdp_pkg::ST_EVAL;
          end
        end
        pdp_pkg::ST_EVAL: begin
          if (eval_go) begin
            state          <= pdp_pkg::ST_LOOK;
            vld[cur_set]   <= 1'b1;
            prior_distance <= cur.distance;
          end
        end
        default: begin
          state <= pdp_pkg::ST_LOOK;
        end
      endcase
      if (eval_go && emit) begin
        out_valid <= 1'b1;
      end else if (prefetch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_go) begin
      cur <= head;
    end
    if (eval_go && emit) begin
      out_addr <= pf_addr;
    end
  end

  assign prefetch.valid            = out_valid;
  assign prefetch.prefetch_address = out_addr;
  // One successor slot: every prefetch is the last of its access.
  assign prefetch.last_prefetch    = 1'b1;

endmodule

>>> rtl/core/pdp_checker.sv
// ----------------------------------------------------------------------------
// pdp_checker: port-level checks of the prefetcher
// Watch handshakes and result stability on the top-level ports.
// ----------------------------------------------------------------------------
module pdp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pdp_pkg::ADDR_W-1:0] out_addr,
  input logic                       out_last
);

  // Hold a stalled prefetch.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_addr))
    else $error("prefetch changed while stalled");

  // Drop everything on reset: no result, room for an access.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

  // One slot per entry: each prefetch closes its access.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_last)
    else $error("prefetch not marked last");

  // Never leave access ready unknown while an access is offered.
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !$isunknown(in_ready))
    else $error("access ready unknown");

endmodule

bind page_distance_prefetcher_core pdp_checker u_pdp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (access.valid),
  .in_ready  (access.ready),
  .out_valid (prefetch.valid),
  .out_ready (prefetch.ready),
  .out_addr  (prefetch.prefetch_address),
  .out_last  (prefetch.last_prefetch)
);

>>> tb/sv/page_distance_prefetcher_core_tb.sv
// ----------------------------------------------------------------------------
// page_distance_prefetcher_core_tb: self-checking bench for the prefetcher
// Drives demand accesses, predicts the prefetches from a behavioral copy
// of the distance table and compares every prefetch item in order.
// ----------------------------------------------------------------------------
module page_distance_prefetcher_core_tb;

  localparam int          NUM_SETS    = pdp_pkg::TABLE_SETS;
  localparam int          SETTLE_CYC  = 20;    // back end drain after the last item
  localparam int          STALL_LIMIT = 4000;  // cycles with no item moving
  localparam logic [63:0] PAGE        = 64'd1 << pdp_pkg::PAGE_SHIFT;

  typedef struct {
    logic [pdp_pkg::ADDR_W-1:0] address;
    logic                       last;
  } prefetch_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_wdata;

  pdp_access_if   access_ch ();
  pdp_prefetch_if prefetch_ch ();

  page_distance_prefetcher_core dut (
    .clk      (clk),
    .rst      (rst),
    .access   (access_ch),
    .prefetch (prefetch_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Stimulus and scoreboard state.
  logic [pdp_pkg::ADDR_W-1:0] pending_accesses [$];
  prefetch_item_t             expected_prefetches [$];
  logic [pdp_pkg::ADDR_W-1:0] tail_address = '0;
  int queued_count    = 0;
  int accepted_count  = 0;
  int checked_count   = 0;
  int silenced_hits   = 0;
  int error_count     = 0;
  int idle_cycles     = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;

  // Behavioral copy of the distance table: one way, one successor slot.
  logic                       model_warmup;
  logic [pdp_pkg::ADDR_W-1:0] model_prior_address;
  pdp_pkg::dist_t             model_prior_distance;
  logic                       page_tag_valid [NUM_SETS];
  pdp_pkg::dist_t             page_tag       [NUM_SETS];
  logic                       successor_valid[NUM_SETS];
  pdp_pkg::dist_t             successor      [NUM_SETS];

  // Advance the table by one accepted access and queue the prefetches it causes.
  task automatic learn_access(input logic [pdp_pkg::ADDR_W-1:0] addr);
    logic signed [pdp_pkg::ADDR_W-1:0] delta_bytes;
    logic signed [pdp_pkg::ADDR_W-1:0] delta_pages;
    pdp_pkg::dist_t                    distance;
    int                                cur_set;
    int                                prev_set;
    prefetch_item_t                    item;
    delta_bytes = addr - model_prior_address;
    delta_pages = delta_bytes >>> pdp_pkg::PAGE_SHIFT;
    distance    = delta_pages[pdp_pkg::DIST_W-1:0];
    cur_set     = int'(distance % NUM_SETS);
    // Hit: issue from the list as it stands before this access links into it.
    if (page_tag_valid[cur_set] && page_tag[cur_set] == distance) begin
      if (successor_valid[cur_set]) begin
        if (model_warmup) begin
          silenced_hits++;
        end else begin
          item.address = addr + {successor[cur_set], {pdp_pkg::PAGE_SHIFT{1'b0}}};
          item.last    = 1'b1;
          expected_prefetches.push_back(item);
        end
      end
    end else begin
      // Miss: take over the set with an empty successor list.
      page_tag_valid[cur_set]  = 1'b1;
      page_tag[cur_set]        = distance;
      successor_valid[cur_set] = 1'b0;
    end
    // Link the previous distance to this one, unless the fill just evicted it.
    prev_set = int'(model_prior_distance % NUM_SETS);
    if (page_tag_valid[prev_set] && page_tag[prev_set] == model_prior_distance) begin
      successor_valid[prev_set] = 1'b1;
      successor[prev_set]       = distance;
    end
    model_prior_address  = addr;
    model_prior_distance = distance;
  endtask

  task automatic queue_access(input logic [pdp_pkg::ADDR_W-1:0] addr);
    pending_accesses.push_back(addr);
    queued_count++;
    tail_address = addr;
  endtask

  // Mostly repeated page-delta patterns so the table hits; some raw noise.
  task automatic queue_random_accesses(input int count);
    int                                step_pages [4];
    int                                plen;
    int                                reps;
    int                                added;
    logic [11:0]                       offset;
    logic signed [pdp_pkg::ADDR_W-1:0] delta;
    logic [pdp_pkg::ADDR_W-1:0]        addr;
    addr  = tail_address;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 20) begin
        addr = {$urandom, $urandom};
        queue_access(addr);
        added++;
      end else begin
        plen   = $urandom_range(4, 1);
        reps   = $urandom_range(4, 2);
        offset = 12'($urandom_range(4095));
        for (int i = 0; i < plen; i++) begin
          case ($urandom_range(5))
            0: step_pages[i] = 0;
            // Same set as a small distance, different tag unless the multiple is zero: forces evictions.
            1: step_pages[i] = (int'($urandom_range(3)) - 1) * NUM_SETS
                               + int'($urandom_range(3));
            default: step_pages[i] = int'($urandom_range(12)) - 4;
          endcase
        end
        for (int r = 0; r < reps; r++) begin
          for (int i = 0; i < plen; i++) begin
            if (added < count) begin
              delta = pdp_pkg::ADDR_W'(step_pages[i]);
              addr  = addr + (delta <<< pdp_pkg::PAGE_SHIFT);
              // Keep the in-page offset fixed mostly; jitter it now and then.
              if ($urandom_range(9) == 0) addr[11:0] = 12'($urandom);
              else addr[11:0] = offset;
              queue_access(addr);
              added++;
            end
          end
        end
      end
    end
  endtask

  // Hold until every queued access is in and every prefetch is out, then drain.
  task automatic wait_idle();
    while (accepted_count != queued_count || expected_prefetches.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_warmup(input logic value);
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= value;
    model_warmup  = value;
    @(posedge clk);
    cfg_we       <= 1'b0;
  endtask

  // Access driver: advance to the next pending item once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      access_ch.valid <= 1'b0;
    end else begin
      if (access_ch.valid && access_ch.ready) begin
        learn_access(access_ch.access_address);
        accepted_count++;
      end
      if (!access_ch.valid || access_ch.ready) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          access_ch.valid          <= 1'b1;
          access_ch.access_address <= pending_accesses.pop_front();
        end else begin
          access_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Prefetch monitor: compare each taken item with the oldest prediction.
  always @(posedge clk) begin
    prefetch_item_t want;
    if (rst) begin
      prefetch_ch.ready <= 1'b0;
    end else begin
      if (prefetch_ch.valid && prefetch_ch.ready) begin
        checked_count++;
        if (expected_prefetches.size() == 0) begin
          $error("prefetch_address: no prefetch expected, got %h",
                 prefetch_ch.prefetch_address);
          error_count++;
        end else begin
          want = expected_prefetches.pop_front();
          if (prefetch_ch.prefetch_address !== want.address) begin
            $error("prefetch_address: expected %h, got %h",
                   want.address, prefetch_ch.prefetch_address);
            error_count++;
          end
          if (prefetch_ch.last_prefetch !== want.last) begin
            $error("last_prefetch: expected %b, got %b",
                   want.last, prefetch_ch.last_prefetch);
            error_count++;
          end
        end
      end
      prefetch_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((access_ch.valid && access_ch.ready) || (prefetch_ch.valid && prefetch_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("[page_distance_prefetcher_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    access_ch.valid          = 1'b0;
    access_ch.access_address = '0;
    prefetch_ch.ready        = 1'b0;
    cfg_we                   = 1'b0;
    cfg_wdata                = 1'b0;
    model_warmup             = 1'b0;
    model_prior_address      = '0;
    model_prior_distance     = '0;
    for (int s = 0; s < NUM_SETS; s++) begin
      page_tag_valid[s]  = 1'b0;
      page_tag[s]        = '0;
      successor_valid[s] = 1'b0;
      successor[s]       = '0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, sender gaps light and receiver stalls heavy.
    send_idle_pct = 13;
    recv_idle_pct = 79;
    write_warmup(1'b0);
    // Zero distance three times: current equals prior, list read before the link.
    queue_access(64'd0);
    queue_access(64'd0);
    queue_access(64'd0);
    // Repeat a +3, +5, 0 page pattern so links form and then fire.
    queue_access(3 * PAGE);
    queue_access(8 * PAGE);
    queue_access(8 * PAGE);
    queue_access(11 * PAGE);
    queue_access(16 * PAGE);
    queue_access(16 * PAGE);
    queue_access(19 * PAGE);
    // +67 pages lands in the set of +3 and evicts the prior entry before its link.
    queue_access(86 * PAGE);
    // Negative distance, repeated until it prefetches backward.
    queue_access(85 * PAGE);
    queue_access(84 * PAGE);
    queue_access(83 * PAGE);
    // Address extremes and sign of the distance at the top bit.
    queue_access(64'hFFFF_FFFF_FFFF_FFFF);
    queue_access(64'h0000_0000_0000_0000);
    queue_access(64'h8000_0000_0000_0000);
    queue_access(64'h7FFF_FFFF_FFFF_F000);
    // Stride of two pages at the top of memory: the prefetch wraps past zero.
    queue_access(64'hFFFF_FFFF_FFFF_8000);
    queue_access(64'hFFFF_FFFF_FFFF_A000);
    queue_access(64'hFFFF_FFFF_FFFF_C000);
    queue_access(64'hFFFF_FFFF_FFFF_E000);
    queue_access(64'h0000_0000_0000_0000);
    wait_idle();

    // Warmup on: the table keeps learning, nothing is issued.
    write_warmup(1'b1);
    queue_random_accesses(30);
    wait_idle();

    write_warmup(1'b0);
    queue_random_accesses(60);
    wait_idle();

    // Swap the stall mix: sender gaps heavy, receiver light.
    send_idle_pct = 79;
    recv_idle_pct = 13;
    queue_random_accesses(60);
    wait_idle();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_accesses(60);
    wait_idle();

    if (expected_prefetches.size() != 0) begin
      $error("prefetch_address: %0d expected prefetches never arrived",
             expected_prefetches.size());
      error_count++;
    end

    $display("Run covered %0d accesses and %0d checked prefetches, %0d hits held in warmup,",
             accepted_count, checked_count, silenced_hits);
    $display("with warmup toggled and sender-heavy, receiver-heavy and gap-free stall mixes.");
    if (error_count == 0) begin
      $display("[page_distance_prefetcher_core] OK");
    end else begin
      $display("[page_distance_prefetcher_core] ERROR");
    end
    $finish;
  end

endmodule
